>>> design/valsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valsm_pkg
// Shared types, codes and constants of the vehicle auto-lock state machine.
// ----------------------------------------------------------------------------
package valsm_pkg;

  localparam int TIME_BITS  = 32;
  // compare width for time differences against 32-bit thresholds
  localparam int CMP_W      = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int DELAY_MS_W = 18;
  localparam int MS_PER_S   = 1000;

  localparam int IN_W    = 64;
  localparam int OUT_W   = 8;
  localparam int CFG_A_W = 8;
  localparam int CFG_D_W = 32;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_LOCK_SPEED     = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_UNLOCK_DELAY_S = 8'd1;
  localparam logic [CFG_A_W-1:0] REG_AUTO_LOCK_EN   = 8'd2;
  localparam logic [CFG_A_W-1:0] REG_AUTO_UNLOCK_EN = 8'd3;
  localparam logic [CFG_A_W-1:0] REG_AUTO_LIGHTS_EN = 8'd4;
  localparam logic [CFG_A_W-1:0] REG_PARK_LP_MS     = 8'd5;
  localparam logic [CFG_A_W-1:0] REG_SILENT_LP_MS   = 8'd6;

  // result bit positions in m_tdata
  localparam int OUT_LOCK_BIT   = 3;
  localparam int OUT_UNLOCK_BIT = 4;
  localparam int OUT_LON_BIT    = 5;
  localparam int OUT_LOFF_BIT   = 6;
  localparam int OUT_LP_BIT     = 7;

  typedef enum logic [2:0] {
    ST_ACC     = 3'd0,
    ST_ENGON   = 3'd1,
    ST_DRIVE   = 3'd2,
    ST_LCRUISE = 3'd3,
    ST_LSTOP   = 3'd4,
    ST_REARM   = 3'd5,
    ST_ENGOFF  = 3'd6,
    ST_PARKED  = 3'd7
  } drive_state_t;

  typedef enum logic [1:0] {
    GEAR_UNKNOWN = 2'd0,
    GEAR_NO_DATA = 2'd1,
    GEAR_PARK    = 2'd2,
    GEAR_OTHER   = 2'd3
  } gear_t;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  typedef struct packed {
    tstamp_t            now;
    logic signed [14:0] rpm;
    logic signed [8:0]  speed;
    gear_t              gear;
    logic               door;
    logic               poll;
    logic               lights;
  } tick_t;

  typedef struct packed {
    logic [7:0]            lock_kph;
    logic [DELAY_MS_W-1:0] unlock_ms;
    logic                  auto_lock_en;
    logic                  auto_unlock_en;
    logic                  auto_lights_en;
    logic [31:0]           park_lowpower_ms;
    logic [31:0]           silent_lowpower_ms;
  } cfg_t;

  typedef struct packed {
    drive_state_t cur_state;
    tstamp_t      entered_time;
    tstamp_t      off_time;
    tstamp_t      last_good_poll_time;
    logic         prev_door;
    logic         door_pending;
    logic         last_gear_park;
  } ctx_t;

  typedef struct packed {
    logic         low_power;
    logic         cmd_lights_off;
    logic         cmd_lights_on;
    logic         do_unlock;
    logic         do_lock;
    drive_state_t drive_state;
  } result_t;

endpackage

>>> design/vehicle_auto_lock_state_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_auto_lock_state_machine
// Eight-state driving machine issuing auto lock, unlock and lights commands.
// ----------------------------------------------------------------------------
// path: tick request into the input register, then result into the result register
// throughput: one tick per cycle while m_tready does not stall the result, set by
//   the combinational transition logic between the input and result registers
// reset: synchronous rst clears state to accessory on, times and flags to 0,
//   and loads the default register values; a pending request or result is dropped
module vehicle_auto_lock_state_machine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // time_ms[31:0], rpm[46:32], speed[55:47], gear_code[57:56],
  // door_open[58], poll_ok[59], lights_active[60], zero fill[63:61]
  input  logic [valsm_pkg::IN_W-1:0]     s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // drive_state[2:0], do_lock[3], do_unlock[4], cmd_lights_on[5],
  // cmd_lights_off[6], low_power[7]
  output logic [valsm_pkg::OUT_W-1:0]    m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [valsm_pkg::CFG_A_W-1:0]  cfg_index,
  input  logic [valsm_pkg::CFG_D_W-1:0]  cfg_data
);
  import valsm_pkg::*;

  logic    in_valid;
  tick_t   tick_in;
  tick_t   tick_q;
  logic    advance;
  cfg_t    cfg;
  ctx_t    ctx;
  ctx_t    ctx_next;
  result_t res;
  result_t res_q;

  assign tick_in.now    = TIME_BITS'(s_tdata[31:0]);
  assign tick_in.rpm    = s_tdata[46:32];
  assign tick_in.speed  = s_tdata[55:47];
  assign tick_in.gear   = gear_t'(s_tdata[57:56]);
  assign tick_in.door   = s_tdata[58];
  assign tick_in.poll   = s_tdata[59];
  assign tick_in.lights = s_tdata[60];

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      tick_q <= tick_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_kph           <= 8'd20;
      cfg.unlock_ms          <= DELAY_MS_W'(3 * MS_PER_S);
      cfg.auto_lock_en       <= 1'b1;
      cfg.auto_unlock_en     <= 1'b1;
      cfg.auto_lights_en     <= 1'b1;
      cfg.park_lowpower_ms   <= 32'd30000;
      cfg.silent_lowpower_ms <= 32'd60000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCK_SPEED:     cfg.lock_kph   <= cfg_data[7:0];
        // seconds converted to milliseconds once, at write time
        REG_UNLOCK_DELAY_S: cfg.unlock_ms  <=
                              DELAY_MS_W'(32'(cfg_data[7:0]) * 32'(MS_PER_S));
        REG_AUTO_LOCK_EN:   cfg.auto_lock_en       <= cfg_data[0];
        REG_AUTO_UNLOCK_EN: cfg.auto_unlock_en     <= cfg_data[0];
        REG_AUTO_LIGHTS_EN: cfg.auto_lights_en     <= cfg_data[0];
        REG_PARK_LP_MS:     cfg.park_lowpower_ms   <= cfg_data;
        REG_SILENT_LP_MS:   cfg.silent_lowpower_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  valsm_core u_core (
    .tick     (tick_q),
    .cfg      (cfg),
    .ctx      (ctx),
    .ctx_next (ctx_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.cur_state           <= ST_ACC;
      ctx.entered_time        <= '0;
      ctx.off_time            <= '0;
      ctx.last_good_poll_time <= '0;
      ctx.prev_door           <= 1'b0;
      ctx.door_pending        <= 1'b0;
      ctx.last_gear_park      <= 1'b0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = res_q;

endmodule

>>> design/valsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valsm_core
// Next-state and command logic for one evaluation tick.
// ----------------------------------------------------------------------------
module valsm_core (
  input  valsm_pkg::tick_t   tick,
  input  valsm_pkg::cfg_t    cfg,
  input  valsm_pkg::ctx_t    ctx,
  output valsm_pkg::ctx_t    ctx_next,
  output valsm_pkg::result_t res
);
  import valsm_pkg::*;

  logic         gear_park_upd;
  logic         running;
  logic         engine_stopped;
  logic         spd_pos;
  logic         spd_zero;
  logic         spd_ge_ls;
  logic         off_elapsed;
  logic         go_off;
  logic         driving;
  logic         park_lp;
  logic         silent_lp;
  drive_state_t state_next;
  tstamp_t      off_diff;
  tstamp_t      park_diff;
  tstamp_t      poll_diff;
  tstamp_t      entered_upd;
  tstamp_t      poll_upd;

  always_comb begin
    case (tick.gear)
      GEAR_PARK:  gear_park_upd = 1'b1;
      GEAR_OTHER: gear_park_upd = 1'b0;
      default:    gear_park_upd = ctx.last_gear_park;
    endcase
  end

  assign running   = !tick.rpm[14] && (tick.rpm != '0);
  assign engine_stopped = (tick.rpm == '0) &&
                     ((tick.gear == GEAR_PARK) || ((tick.gear == GEAR_UNKNOWN) && gear_park_upd));
  assign spd_pos   = !tick.speed[8] && (tick.speed != '0);
  assign spd_zero  = (tick.speed == '0);
  assign spd_ge_ls = tick.speed >= $signed({1'b0, cfg.lock_kph});

  assign off_diff    = tick.now - ctx.off_time;
  assign off_elapsed = CMP_W'(off_diff) >= CMP_W'(cfg.unlock_ms);

  always_comb begin
    ctx_next = ctx;
    res      = '0;
    go_off   = 1'b0;
    state_next = ctx.cur_state;

    if (tick.poll) begin
      ctx_next.last_good_poll_time = tick.now;
    end
    ctx_next.last_gear_park = gear_park_upd;
    // door closing edge arms the re-arm path
    if (ctx.prev_door && !tick.door) begin
      ctx_next.door_pending = 1'b1;
    end
    ctx_next.prev_door = tick.door;

    case (ctx.cur_state)
      ST_ACC, ST_PARKED: begin
        if (running) begin
          state_next        = ST_ENGON;
          res.cmd_lights_on = cfg.auto_lights_en;
        end
      end
      ST_ENGON: begin
        if (engine_stopped) begin
          go_off = 1'b1;
        end else if (spd_pos) begin
          state_next = ST_DRIVE;
        end
      end
      ST_DRIVE, ST_REARM: begin
        if (engine_stopped) begin
          go_off = 1'b1;
        end else if (spd_ge_ls) begin
          res.do_lock = cfg.auto_lock_en;
          state_next  = ST_LCRUISE;
        end
      end
      ST_LCRUISE: begin
        if (engine_stopped) begin
          go_off = 1'b1;
        end else if (spd_zero) begin
          ctx_next.door_pending = 1'b0;
          state_next            = ST_LSTOP;
        end
      end
      ST_LSTOP: begin
        if (engine_stopped) begin
          go_off = 1'b1;
        end else if (spd_pos) begin
          state_next = ST_LCRUISE;
        end else if (ctx_next.door_pending) begin
          ctx_next.door_pending = 1'b0;
          state_next            = ST_REARM;
        end
      end
      ST_ENGOFF: begin
        if (running) begin
          state_next = ST_ENGON;
        end else if (off_elapsed) begin
          res.do_unlock      = cfg.auto_unlock_en;
          res.cmd_lights_off = tick.lights;
          state_next         = ST_PARKED;
        end
      end
      default: begin
      end
    endcase

    if (go_off) begin
      ctx_next.off_time = tick.now;
      state_next        = ST_ENGOFF;
    end
    if (state_next != ctx.cur_state) begin
      ctx_next.entered_time = tick.now;
    end
    ctx_next.cur_state = state_next;

    res.drive_state = state_next;
    res.low_power   = park_lp || silent_lp;
  end

  // low power looks at the updated state and timestamps
  assign entered_upd = (state_next != ctx.cur_state) ? tick.now : ctx.entered_time;
  assign poll_upd    = tick.poll ? tick.now : ctx.last_good_poll_time;
  assign park_diff   = tick.now - entered_upd;
  assign poll_diff   = tick.now - poll_upd;
  assign driving     = state_next inside {ST_ENGON, ST_DRIVE, ST_LCRUISE, ST_LSTOP, ST_REARM};
  assign park_lp     = (state_next == ST_PARKED) &&
                       (CMP_W'(park_diff) >= CMP_W'(cfg.park_lowpower_ms));
  assign silent_lp   = !driving && (CMP_W'(poll_diff) >= CMP_W'(cfg.silent_lowpower_ms));

endmodule

>>> design/valsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valsm_checker
// Port-level assertions for the vehicle auto-lock state machine.
// ----------------------------------------------------------------------------
module valsm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [valsm_pkg::OUT_W-1:0] m_tdata
);
  import valsm_pkg::*;

  a_rst_no_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // lock only on entry to locked cruising
  a_lock_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_LOCK_BIT] |-> m_tdata[2:0] == ST_LCRUISE)
    else $error("lock request outside locked cruising");

  // unlock and lights off only on entry to parked
  a_park_cmds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUT_UNLOCK_BIT] || m_tdata[OUT_LOFF_BIT])
      |-> m_tdata[2:0] == ST_PARKED)
    else $error("unlock or lights off outside parked");

  a_lon_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_LON_BIT] |-> m_tdata[2:0] == ST_ENGON)
    else $error("lights on outside engine on");

endmodule

bind vehicle_auto_lock_state_machine valsm_checker u_valsm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
